>>> hw/rtl/kaf_pkg.sv
package kaf_pkg;

    // Fixed-point constants
    localparam int DW = 32;
    localparam logic signed [31:0] ONE_Q   = 32'sd65536;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;

    // Configuration port
    localparam int DT_W      = 17;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        CFG_TIME_STEP  = 2'd0,
        CFG_PROC_NOISE = 2'd1,
        CFG_MEAS_XY    = 2'd2,
        CFG_MEAS_Z     = 2'd3
    } t_cfg_idx;

    // Operand sources: memory regions first, then generated matrices
    typedef enum logic [4:0] {
        SRC_PU, SRC_PP, SRC_TM, SRC_T3, SRC_SM, SRC_PH, SRC_KM,
        SRC_XU, SRC_XP, SRC_HX, SRC_KX,
        SRC_A, SRC_AT, SRC_B, SRC_H, SRC_HT, SRC_U, SRC_I, SRC_Q, SRC_Z
    } t_src;

    typedef enum logic [1:0] {DM_ONE, DM_AX, DM_NS} t_dim;

    typedef enum logic [1:0] {OP_MM, OP_EW, OP_RCP} t_kind;

    typedef struct packed {
        t_kind kind;
        logic  sub;
        logic  to_out;
        t_src  a;
        t_src  b;
        t_src  dst;
        t_dim  n;
        t_dim  k;
        t_dim  m;
    } t_desc;

    typedef struct packed {
        logic ew;
        logic sub;
        logic first;
        logic last;
    } t_mac_ctl;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ISSUE, ST_DRAIN, ST_RCP_RD, ST_RCP_DAT, ST_RCP_DIV, ST_RCP_WR, ST_DONE
    } t_seq_state;

    typedef enum logic [1:0] {RS_IDLE, RS_RUN, RS_FIN} t_rcp_state;

    // Step ranges of the sequencer program
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_INIT_FIRST = 5'd0;
    localparam logic [STEP_W-1:0] STEP_INIT_LAST  = 5'd3;
    localparam logic [STEP_W-1:0] STEP_PRED_FIRST = 5'd4;
    localparam logic [STEP_W-1:0] STEP_PRED_LAST  = 5'd9;
    localparam logic [STEP_W-1:0] STEP_CORR_FIRST = 5'd10;
    localparam logic [STEP_W-1:0] STEP_CORR_LAST  = 5'd21;

    function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return S32_MAX;
        if (v < -64'sd2147483648) return S32_MIN;
        return v[31:0];
    endfunction

    function automatic t_desc mk(input t_kind kind, input logic sub, input logic to_out,
                                 input t_src a, input t_src b, input t_src dst,
                                 input t_dim n, input t_dim k, input t_dim m);
        t_desc d;
        d.kind   = kind;
        d.sub    = sub;
        d.to_out = to_out;
        d.a      = a;
        d.b      = b;
        d.dst    = dst;
        d.n      = n;
        d.k      = k;
        d.m      = m;
        return d;
    endfunction

    // Sequencer program: clearing pass, predict, correct
    function automatic t_desc prog(input logic [STEP_W-1:0] step);
        t_desc d;
        d = mk(OP_EW, 1'b0, 1'b0, SRC_Z, SRC_Z, SRC_KX, DM_ONE, DM_ONE, DM_ONE);
        unique case (step)
            5'd0:  d = mk(OP_EW, 1'b0, 1'b0, SRC_I,  SRC_Z,  SRC_PU, DM_NS, DM_ONE, DM_NS);
            5'd1:  d = mk(OP_EW, 1'b0, 1'b0, SRC_I,  SRC_Z,  SRC_PP, DM_NS, DM_ONE, DM_NS);
            5'd2:  d = mk(OP_EW, 1'b0, 1'b0, SRC_Z,  SRC_Z,  SRC_XU, DM_NS, DM_ONE, DM_ONE);
            5'd3:  d = mk(OP_EW, 1'b0, 1'b0, SRC_Z,  SRC_Z,  SRC_XP, DM_NS, DM_ONE, DM_ONE);
            5'd4:  d = mk(OP_MM, 1'b0, 1'b0, SRC_A,  SRC_XU, SRC_TM, DM_NS, DM_NS, DM_ONE);
            5'd5:  d = mk(OP_MM, 1'b0, 1'b0, SRC_B,  SRC_U,  SRC_KX, DM_NS, DM_AX, DM_ONE);
            5'd6:  d = mk(OP_EW, 1'b0, 1'b1, SRC_TM, SRC_KX, SRC_XP, DM_NS, DM_ONE, DM_ONE);
            5'd7:  d = mk(OP_MM, 1'b0, 1'b0, SRC_A,  SRC_PU, SRC_TM, DM_NS, DM_NS, DM_NS);
            5'd8:  d = mk(OP_MM, 1'b0, 1'b0, SRC_TM, SRC_AT, SRC_T3, DM_NS, DM_NS, DM_NS);
            5'd9:  d = mk(OP_EW, 1'b0, 1'b0, SRC_T3, SRC_Q,  SRC_PP, DM_NS, DM_ONE, DM_NS);
            5'd10: d = mk(OP_MM, 1'b0, 1'b0, SRC_H,  SRC_PP, SRC_TM, DM_AX, DM_NS, DM_NS);
            5'd11: d = mk(OP_MM, 1'b0, 1'b0, SRC_TM, SRC_HT, SRC_SM, DM_AX, DM_NS, DM_AX);
            5'd12: d = mk(OP_RCP, 1'b0, 1'b0, SRC_SM, SRC_Z, SRC_SM, DM_AX, DM_ONE, DM_ONE);
            5'd13: d = mk(OP_MM, 1'b0, 1'b0, SRC_PP, SRC_HT, SRC_PH, DM_NS, DM_NS, DM_AX);
            5'd14: d = mk(OP_MM, 1'b0, 1'b0, SRC_PH, SRC_SM, SRC_KM, DM_NS, DM_AX, DM_AX);
            5'd15: d = mk(OP_MM, 1'b0, 1'b0, SRC_H,  SRC_XP, SRC_HX, DM_AX, DM_NS, DM_ONE);
            5'd16: d = mk(OP_EW, 1'b1, 1'b0, SRC_U,  SRC_HX, SRC_HX, DM_AX, DM_ONE, DM_ONE);
            5'd17: d = mk(OP_MM, 1'b0, 1'b0, SRC_KM, SRC_HX, SRC_KX, DM_NS, DM_AX, DM_ONE);
            5'd18: d = mk(OP_EW, 1'b0, 1'b1, SRC_XP, SRC_KX, SRC_XU, DM_NS, DM_ONE, DM_ONE);
            5'd19: d = mk(OP_MM, 1'b0, 1'b0, SRC_KM, SRC_H,  SRC_TM, DM_NS, DM_AX, DM_NS);
            5'd20: d = mk(OP_EW, 1'b1, 1'b0, SRC_I,  SRC_TM, SRC_TM, DM_NS, DM_ONE, DM_NS);
            5'd21: d = mk(OP_MM, 1'b0, 1'b0, SRC_TM, SRC_PP, SRC_PU, DM_NS, DM_NS, DM_NS);
            default: d = mk(OP_EW, 1'b0, 1'b0, SRC_Z, SRC_Z, SRC_KX, DM_ONE, DM_ONE, DM_ONE);
        endcase
        return d;
    endfunction

endpackage

>>> hw/rtl/kalman_attitude_filter_3axis.sv
// Channel   Handshake                   Payload
// input     i_in_valid / o_in_ready     i_mode, i_value_a, i_value_b, i_value_c
// output    o_out_valid / i_out_ready   o_was_correct, o_angle_*, o_bias_* (a, b, c)
// config    i_cfg_we                    i_cfg_idx, i_cfg_data
//
// The shared multiply-accumulate unit takes one product per cycle and drains after
// each matrix step, and each reciprocal on the diagonal of S is formed in the
// bit-serial divider.
// After reset a clearing pass of 2*NS*NS + 2*NS element writes plus drain loads the
// covariances; no item is taken meanwhile.
// A finished result waits in the output register while the next item is taken.
module kalman_attitude_filter_3axis import kaf_pkg::*; #(
    parameter int AXES = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_mode,
    input  logic signed [31:0]   i_value_a,
    input  logic signed [31:0]   i_value_b,
    input  logic signed [31:0]   i_value_c,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_was_correct,
    output logic signed [31:0]   o_angle_a,
    output logic signed [31:0]   o_bias_a,
    output logic signed [31:0]   o_angle_b,
    output logic signed [31:0]   o_bias_b,
    output logic signed [31:0]   o_angle_c,
    output logic signed [31:0]   o_bias_c,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int NS    = 2 * AXES;
    localparam int SQ    = NS * NS;
    localparam int B_PU  = 0;
    localparam int B_PP  = SQ;
    localparam int B_TM  = 2 * SQ;
    localparam int B_T3  = 3 * SQ;
    localparam int B_SM  = 4 * SQ;
    localparam int B_PH  = B_SM + AXES * AXES;
    localparam int B_KM  = B_PH + NS * AXES;
    localparam int B_XU  = B_KM + NS * AXES;
    localparam int B_XP  = B_XU + NS;
    localparam int B_HX  = B_XP + NS;
    localparam int B_KX  = B_HX + AXES;
    localparam int DEPTH = B_KX + NS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(NS + 1);
    localparam int IW    = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int OUT_N = 6;
    localparam int TAG_W = 1 + CW + AW;

    function automatic logic [CW-1:0] dimv(input t_dim dm);
        unique case (dm)
            DM_ONE:  return CW'(1);
            DM_AX:   return CW'(AXES);
            DM_NS:   return CW'(NS);
            default: return CW'(1);
        endcase
    endfunction

    function automatic logic [AW-1:0] base(input t_src src);
        unique case (src)
            SRC_PU:  return AW'(B_PU);
            SRC_PP:  return AW'(B_PP);
            SRC_TM:  return AW'(B_TM);
            SRC_T3:  return AW'(B_T3);
            SRC_SM:  return AW'(B_SM);
            SRC_PH:  return AW'(B_PH);
            SRC_KM:  return AW'(B_KM);
            SRC_XU:  return AW'(B_XU);
            SRC_XP:  return AW'(B_XP);
            SRC_HX:  return AW'(B_HX);
            SRC_KX:  return AW'(B_KX);
            default: return AW'(0);
        endcase
    endfunction

    function automatic logic is_gen(input t_src src);
        case (src) inside
            SRC_A, SRC_AT, SRC_B, SRC_H, SRC_HT, SRC_U, SRC_I, SRC_Q, SRC_Z: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [AW-1:0] addr(input t_src src, input logic [CW-1:0] row,
                                           input logic [CW-1:0] col, input logic [CW-1:0] cols);
        return base(src) + AW'(row) * AW'(cols) + AW'(col);
    endfunction

    // Element of a generated matrix at (row, col)
    function automatic logic signed [31:0] gen(input t_src src, input logic [CW-1:0] row,
                                               input logic [CW-1:0] col,
                                               input logic signed [31:0] dt,
                                               input logic signed [31:0] noise,
                                               input logic signed [31:0] uval);
        logic diag, even;
        diag = (row == col);
        even = !row[0];
        unique case (src)
            SRC_A:   return diag ? ONE_Q : ((even && col == row + CW'(1)) ? 32'sd0 - dt : 32'sd0);
            SRC_AT:  return diag ? ONE_Q : ((!col[0] && row == col + CW'(1)) ? 32'sd0 - dt
                                                                              : 32'sd0);
            SRC_B:   return (even && (row >> 1) == col) ? dt : 32'sd0;
            SRC_H:   return (col == (row << 1)) ? ONE_Q : 32'sd0;
            SRC_HT:  return (row == (col << 1)) ? ONE_Q : 32'sd0;
            SRC_U:   return uval;
            SRC_I:   return diag ? ONE_Q : 32'sd0;
            SRC_Q:   return diag ? noise : 32'sd0;
            default: return 32'sd0;
        endcase
    endfunction

    // Configuration registers
    logic [DT_W-1:0]  r_dt;
    logic [CFG_W-1:0] r_qn, r_rxy, r_rz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt  <= DT_W'(655);
            r_qn  <= CFG_W'(655);
            r_rxy <= CFG_W'(6554);
            r_rz  <= CFG_W'(65536);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TIME_STEP:  r_dt  <= i_cfg_data[DT_W-1:0];
                CFG_PROC_NOISE: r_qn  <= i_cfg_data;
                CFG_MEAS_XY:    r_rxy <= i_cfg_data;
                CFG_MEAS_Z:     r_rz  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer state
    t_seq_state         r_state, n_state;
    logic [STEP_W-1:0]  r_step, r_end;
    logic               r_init, r_mode;
    logic [CW-1:0]      r_i, r_j, r_t;
    logic signed [31:0] r_u   [AXES];
    logic signed [31:0] r_res [OUT_N];
    logic signed [31:0] r_out [OUT_N];
    logic               r_out_corr, r_out_valid;

    // Fetch stage
    logic               r_f_valid, r_f_a_gen, r_f_b_gen;
    logic signed [31:0] r_f_ga, r_f_gb;
    t_mac_ctl           r_f_ctl;
    logic [TAG_W-1:0]   r_f_tag;

    t_desc              d, d_next;
    logic               ew, first_t, last_t, last_j, last_i, issue_last;
    logic [CW-1:0]      dn, dk, dm;
    logic [CW-1:0]      a_col, a_cols, b_row;
    logic [AW-1:0]      a_addr, b_addr, dst_addr, diag_addr, rd_addr_a;
    logic signed [31:0] ua, ub, dt32, qn32, rn32;
    logic signed [31:0] ram_a, ram_b, op_a, op_b;
    logic               in_acc, out_free, pipe_idle;
    logic               mac_wr_valid, mac_busy;
    logic [TAG_W-1:0]   mac_wr_tag;
    logic signed [31:0] mac_wr_data;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;
    logic               rcp_start, rcp_done;
    logic signed [31:0] rcp_den, rcp_quo;
    logic [CW-1:0]      tag_row;
    logic               tag_out;
    t_mac_ctl           iss_ctl;

    // Element indexing of the current step
    always_comb begin
        d          = prog(r_step);
        d_next     = prog(r_step + STEP_W'(1));
        ew         = (d.kind == OP_EW);
        dn         = dimv(d.n);
        dk         = dimv(d.k);
        dm         = dimv(d.m);
        a_col      = ew ? r_j : r_t;
        a_cols     = ew ? dm : dk;
        b_row      = ew ? r_i : r_t;
        first_t    = ew || (r_t == '0);
        last_t     = ew || (r_t == dk - CW'(1));
        last_j     = (r_j == dm - CW'(1));
        last_i     = (r_i == dn - CW'(1));
        issue_last = last_t && last_j && last_i;
        a_addr     = addr(d.a, r_i, a_col, a_cols);
        b_addr     = addr(d.b, b_row, r_j, dm);
        dst_addr   = addr(d.dst, r_i, r_j, dm);
        diag_addr  = AW'(B_SM) + AW'(r_i) * AW'(AXES + 1);
        dt32       = {{(32 - DT_W){1'b0}}, r_dt};
        qn32       = {1'b0, r_qn};
        rn32       = (r_i < CW'(2)) ? {1'b0, r_rxy} : {1'b0, r_rz};
        ua         = (int'(r_i) < AXES) ? r_u[r_i[IW-1:0]] : 32'sd0;
        ub         = (int'(b_row) < AXES) ? r_u[b_row[IW-1:0]] : 32'sd0;
        iss_ctl.ew    = ew;
        iss_ctl.sub   = d.sub;
        iss_ctl.first = first_t;
        iss_ctl.last  = last_t;
    end

    assign in_acc    = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;
    assign pipe_idle = !r_f_valid && !mac_busy;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (in_acc) n_state = ST_ISSUE;
            ST_ISSUE:   if (issue_last) n_state = ST_DRAIN;
            ST_DRAIN: begin
                if (pipe_idle) begin
                    if (r_step == r_end) begin
                        n_state = r_init ? ST_IDLE : ST_DONE;
                    end else begin
                        n_state = (d_next.kind == OP_RCP) ? ST_RCP_RD : ST_ISSUE;
                    end
                end
            end
            ST_RCP_RD:  n_state = ST_RCP_DAT;
            ST_RCP_DAT: n_state = ST_RCP_DIV;
            ST_RCP_DIV: if (rcp_done) n_state = ST_RCP_WR;
            ST_RCP_WR:  n_state = (r_i == CW'(AXES - 1)) ? ST_DRAIN : ST_RCP_RD;
            ST_DONE:    if (out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
        rd_addr_a  = (r_state == ST_RCP_RD) ? diag_addr : a_addr;
        rcp_start  = (r_state == ST_RCP_DAT);
        rcp_den    = sat64({{32{ram_a[31]}}, ram_a} + {{32{rn32[31]}}, rn32});
        wr_en      = mac_wr_valid || (r_state == ST_RCP_WR);
        wr_addr    = (r_state == ST_RCP_WR) ? diag_addr : mac_wr_tag[AW-1:0];
        wr_data    = (r_state == ST_RCP_WR) ? rcp_quo : mac_wr_data;
    end

    assign tag_out = mac_wr_tag[TAG_W-1];
    assign tag_row = mac_wr_tag[AW +: CW];
    assign op_a    = r_f_a_gen ? r_f_ga : ram_a;
    assign op_b    = r_f_b_gen ? r_f_gb : ram_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_ISSUE;
            r_step      <= STEP_INIT_FIRST;
            r_end       <= STEP_INIT_LAST;
            r_init      <= 1'b1;
            r_i         <= '0;
            r_j         <= '0;
            r_t         <= '0;
            r_out_valid <= 1'b0;
            r_f_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_f_valid <= (r_state == ST_ISSUE);
            // Load a new result, or drop the one just taken
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_step <= i_mode ? STEP_CORR_FIRST : STEP_PRED_FIRST;
                        r_end  <= i_mode ? STEP_CORR_LAST : STEP_PRED_LAST;
                        r_init <= 1'b0;
                        r_i    <= '0;
                        r_j    <= '0;
                        r_t    <= '0;
                    end
                end
                // Advance inner, column, then row counter
                ST_ISSUE: begin
                    if (!last_t) begin
                        r_t <= r_t + CW'(1);
                    end else begin
                        r_t <= '0;
                        if (!last_j) begin
                            r_j <= r_j + CW'(1);
                        end else begin
                            r_j <= '0;
                            r_i <= last_i ? '0 : r_i + CW'(1);
                        end
                    end
                end
                ST_DRAIN: begin
                    if (pipe_idle && r_step != r_end) begin
                        r_step <= r_step + STEP_W'(1);
                        r_i    <= '0;
                        r_j    <= '0;
                        r_t    <= '0;
                    end
                end
                ST_RCP_WR: r_i <= (r_i == CW'(AXES - 1)) ? '0 : r_i + CW'(1);
                default: ;
            endcase
        end

        // Capture the item
        if (in_acc) begin
            r_mode <= i_mode;
            for (int ax = 0; ax < AXES; ax++) begin
                case (ax)
                    0:       r_u[ax] <= i_value_a;
                    1:       r_u[ax] <= i_value_b;
                    2:       r_u[ax] <= i_value_c;
                    default: r_u[ax] <= 32'sd0;
                endcase
            end
            for (int k = 0; k < OUT_N; k++) begin
                r_res[k] <= 32'sd0;
            end
        end else if (mac_wr_valid && tag_out && int'(tag_row) < OUT_N) begin
            r_res[3'(tag_row)] <= mac_wr_data;
        end

        // Hold the result for the output channel
        if (r_state == ST_DONE && out_free) begin
            r_out      <= r_res;
            r_out_corr <= r_mode;
        end

        // Operand fetch, aligned with the registered memory read
        r_f_ctl   <= iss_ctl;
        r_f_tag   <= {d.to_out, r_i, dst_addr};
        r_f_a_gen <= is_gen(d.a);
        r_f_b_gen <= is_gen(d.b);
        r_f_ga    <= gen(d.a, r_i, a_col, dt32, qn32, ua);
        r_f_gb    <= gen(d.b, b_row, r_j, dt32, qn32, ub);
    end

    kaf_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (wr_en),
        .i_waddr   (wr_addr),
        .i_wdata   (wr_data),
        .i_raddr_a (rd_addr_a),
        .o_rdata_a (ram_a),
        .i_raddr_b (b_addr),
        .o_rdata_b (ram_b)
    );

    kaf_mac #(
        .TAG_W (TAG_W)
    ) u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_f_valid),
        .i_ctl      (r_f_ctl),
        .i_tag      (r_f_tag),
        .i_a        (op_a),
        .i_b        (op_b),
        .o_wr_valid (mac_wr_valid),
        .o_wr_tag   (mac_wr_tag),
        .o_wr_data  (mac_wr_data),
        .o_busy     (mac_busy)
    );

    kaf_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rcp_start),
        .i_den   (rcp_den),
        .o_done  (rcp_done),
        .o_quo   (rcp_quo)
    );

    assign o_out_valid   = r_out_valid;
    assign o_was_correct = r_out_corr;
    assign o_angle_a     = r_out[0];
    assign o_bias_a      = r_out[1];
    assign o_angle_b     = r_out[2];
    assign o_bias_b      = r_out[3];
    assign o_angle_c     = r_out[4];
    assign o_bias_c      = r_out[5];

    // The pipeline is empty whenever an item may be taken
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> pipe_idle)
        else $error("item taken while pipeline busy");

    // Reciprocal write-back never collides with a pipeline write
    a_wr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mac_wr_valid && r_state == ST_RCP_WR))
        else $error("write port collision");

    // A taken result drops valid unless a new one is loaded
    a_out_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_ready && r_state != ST_DONE) |=> !r_out_valid)
        else $error("result delivered twice");

    // Reciprocal write-back follows a finished division
    a_rcp_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RCP_WR) |-> $past(rcp_done))
        else $error("reciprocal written before division finished");

endmodule

>>> hw/rtl/kaf_ram.sv
module kaf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read two, reads registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= mem[i_raddr_a];
        o_rdata_b <= mem[i_raddr_b];
    end

endmodule

>>> hw/rtl/kaf_recip.sv
module kaf_recip import kaf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_den,
    output logic               o_done,
    output logic signed [31:0] o_quo
);

    t_rcp_state r_state, n_state;
    logic        r_neg, r_zero;
    logic [31:0] r_m;
    logic [31:0] r_rem;
    logic [32:0] r_quo;
    logic [5:0]  r_cnt;
    logic signed [31:0] r_res;
    logic [32:0] trial;
    logic        fits;
    logic [33:0] q_rnd;
    logic signed [31:0] n_res;

    // One quotient bit of 2^32 / |den| per cycle
    assign trial = {r_rem, (r_cnt == 6'd0)};
    assign fits  = trial >= {1'b0, r_m};

    // Round to nearest and saturate
    always_comb begin
        q_rnd = {1'b0, r_quo} + {33'd0, ({r_rem, 1'b0} >= {1'b0, r_m})};
        if (r_zero) begin
            n_res = S32_MAX;
        end else if (!r_neg) begin
            n_res = (q_rnd > 34'h07FFFFFFF) ? S32_MAX : q_rnd[31:0];
        end else begin
            n_res = (q_rnd >= 34'h080000000) ? S32_MIN : 32'sd0 - q_rnd[31:0];
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            RS_IDLE: if (i_start) n_state = RS_RUN;
            RS_RUN:  if (r_cnt == 6'd32) n_state = RS_FIN;
            RS_FIN:  n_state = RS_IDLE;
            default: n_state = RS_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_done = (r_state == RS_FIN);
        o_quo  = r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RS_IDLE;
        end else begin
            r_state <= n_state;
        end
        unique case (r_state)
            RS_IDLE: begin
                if (i_start) begin
                    r_neg  <= i_den[31];
                    r_zero <= (i_den == 32'sd0);
                    r_m    <= i_den[31] ? 32'd0 - i_den : i_den;
                    r_rem  <= 32'd0;
                    r_quo  <= 33'd0;
                    r_cnt  <= 6'd0;
                end
            end
            RS_RUN: begin
                r_rem <= fits ? 32'(trial - {1'b0, r_m}) : trial[31:0];
                r_quo <= {r_quo[31:0], fits};
                r_cnt <= r_cnt + 6'd1;
            end
            RS_FIN: r_res <= n_res;
            default: ;
        endcase
    end

endmodule

>>> hw/rtl/kaf_mac.sv
module kaf_mac import kaf_pkg::*; #(
    parameter int TAG_W = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_mac_ctl           i_ctl,
    input  logic [TAG_W-1:0]   i_tag,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic               o_wr_valid,
    output logic [TAG_W-1:0]   o_wr_tag,
    output logic signed [31:0] o_wr_data,
    output logic               o_busy
);

    logic               r_s1_valid, r_s2_valid, r_wr_valid;
    t_mac_ctl           r_s1_ctl, r_s2_ctl;
    logic [TAG_W-1:0]   r_s1_tag, r_s2_tag, r_wr_tag;
    logic signed [63:0] r_s1_p;
    logic signed [31:0] r_s2_q, r_acc;
    logic signed [63:0] prod, ext_a, ext_b, rnd;
    logic signed [31:0] acc_new;

    assign prod  = i_a * i_b;
    assign ext_a = {{32{i_a[31]}}, i_a};
    assign ext_b = {{32{i_b[31]}}, i_b};
    // Round to nearest, ties away from zero
    assign rnd   = r_s1_p + (r_s1_p[63] ? 64'sd32767 : 64'sd32768);
    assign acc_new = r_s2_ctl.first ? r_s2_q : r_acc + r_s2_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_wr_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_wr_valid <= r_s2_valid && r_s2_ctl.last;
        end
        // Multiply, or add or subtract for an element pass
        r_s1_ctl <= i_ctl;
        r_s1_tag <= i_tag;
        if (i_ctl.ew) begin
            r_s1_p <= i_ctl.sub ? ext_a - ext_b : ext_a + ext_b;
        end else begin
            r_s1_p <= prod;
        end
        // Scale and saturate
        r_s2_ctl <= r_s1_ctl;
        r_s2_tag <= r_s1_tag;
        r_s2_q   <= r_s1_ctl.ew ? sat64(r_s1_p) : sat64(rnd >>> 16);
        // Wrapping accumulate
        if (r_s2_valid) begin
            r_acc <= acc_new;
        end
        r_wr_tag <= r_s2_tag;
    end

    assign o_wr_valid = r_wr_valid;
    assign o_wr_tag   = r_wr_tag;
    assign o_wr_data  = r_acc;
    assign o_busy     = r_s1_valid | r_s2_valid | r_wr_valid;

endmodule

>>> tb/sv/tb_kalman_attitude_filter_3axis.sv
module tb_kalman_attitude_filter_3axis;
    import kaf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSTATE = 6;
    localparam int ONE_FIX = 65536;

    typedef struct packed {
        logic        mode;
        logic [31:0] va;
        logic [31:0] vb;
        logic [31:0] vc;
    } t_sample;

    typedef struct packed {
        logic             corr;
        logic [5:0][31:0] v;
    } t_estimate;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_mode;
    logic signed [31:0]   i_value_a;
    logic signed [31:0]   i_value_b;
    logic signed [31:0]   i_value_c;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic                 o_was_correct;
    logic signed [31:0]   o_angle_a;
    logic signed [31:0]   o_bias_a;
    logic signed [31:0]   o_angle_b;
    logic signed [31:0]   o_bias_b;
    logic signed [31:0]   o_angle_c;
    logic signed [31:0]   o_bias_c;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    kalman_attitude_filter_3axis u_top (.*);

    // Filter shadow: registers, state vectors and covariances
    int unsigned dt_reg;
    int unsigned q_reg;
    int unsigned r_xy_reg;
    int unsigned r_z_reg;
    int x_corr[36];
    int x_pred[36];
    int p_corr[36];
    int p_pred[36];

    t_sample   sample_q[$];
    t_estimate estimate_q[$];
    int        mismatches;
    int        n_results;
    bit        in_taken;
    bit        quiet;
    int        in_gap;
    int        out_gap;
    bit        long_hold_done;

    function automatic int sat_fix(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return int'(v);
    endfunction

    function automatic int mul_fix(int a, int b);
        longint p;
        longint r;
        p = longint'(a) * longint'(b);
        if (p >= 0) r = (p + 32768) >>> 16;
        else        r = -((-p + 32768) >>> 16);
        return sat_fix(r);
    endfunction

    function automatic int add_fix(int a, int b);
        return sat_fix(longint'(a) + longint'(b));
    endfunction

    function automatic int sub_fix(int a, int b);
        return sat_fix(longint'(a) - longint'(b));
    endfunction

    function automatic int recip_fix(int b);
        longint unsigned m;
        longint unsigned q;
        longint unsigned r;
        if (b == 0) return 32'sh7FFFFFFF;
        m = (b > 0) ? longint'(b) : -longint'(b);
        q = (64'd1 << 32) / m;
        r = (64'd1 << 32) % m;
        if (2 * r >= m) q++;
        if (b > 0) return (q > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : int'(q);
        if (q >= 64'h80000000) return 32'sh80000000;
        return -int'(q);
    endfunction

    // Row-major product with wrapping accumulation
    function automatic void mat_mul(output int dst[36], input int a[36], input int b[36],
                                    input int n, input int k, input int m);
        int acc;
        for (int i = 0; i < 36; i++) dst[i] = 0;
        for (int i = 0; i < n; i++)
            for (int j = 0; j < m; j++) begin
                acc = 0;
                for (int t = 0; t < k; t++) acc += mul_fix(a[i*k+t], b[t*m+j]);
                dst[i*m+j] = acc;
            end
    endfunction

    function automatic void time_update(input int u[36]);
        int a[36], at[36], b[36], t1[36], t2[36], tm[36], t3[36];
        int dt;
        dt = int'(dt_reg);
        for (int i = 0; i < 36; i++) begin
            a[i] = 0; at[i] = 0; b[i] = 0;
        end
        for (int i = 0; i < NSTATE; i++) begin
            a[i*NSTATE+i]  = ONE_FIX;
            at[i*NSTATE+i] = ONE_FIX;
        end
        for (int i = 0; i < 3; i++) begin
            a[(2*i)*NSTATE+2*i+1]  = -dt;
            at[(2*i+1)*NSTATE+2*i] = -dt;
            b[(2*i)*3+i]           = dt;
        end
        mat_mul(t1, a, x_corr, NSTATE, NSTATE, 1);
        mat_mul(t2, b, u, NSTATE, 3, 1);
        for (int i = 0; i < NSTATE; i++) x_pred[i] = add_fix(t1[i], t2[i]);
        mat_mul(tm, a, p_corr, NSTATE, NSTATE, NSTATE);
        mat_mul(t3, tm, at, NSTATE, NSTATE, NSTATE);
        for (int i = 0; i < 36; i++)
            p_pred[i] = add_fix(t3[i], (i % (NSTATE + 1) == 0) ? int'(q_reg) : 0);
    endfunction

    function automatic void measurement_update(input int z[36]);
        int h[36], ht[36], hp[36], s[36], ph[36], kg[36];
        int hx[36], y[36], kx[36], kh[36], pn[36];
        int rn;
        for (int i = 0; i < 36; i++) begin
            h[i] = 0; ht[i] = 0; y[i] = 0;
        end
        for (int i = 0; i < 3; i++) begin
            h[i*NSTATE+2*i] = ONE_FIX;
            ht[(2*i)*3+i]   = ONE_FIX;
        end
        mat_mul(hp, h, p_pred, 3, NSTATE, NSTATE);
        mat_mul(s, hp, ht, 3, NSTATE, 3);
        for (int i = 0; i < 3; i++) begin
            rn = int'((i < 2) ? r_xy_reg : r_z_reg);
            s[i*3+i] = recip_fix(add_fix(s[i*3+i], rn));
        end
        mat_mul(ph, p_pred, ht, NSTATE, NSTATE, 3);
        mat_mul(kg, ph, s, NSTATE, 3, 3);
        mat_mul(hx, h, x_pred, 3, NSTATE, 1);
        for (int i = 0; i < 3; i++) y[i] = sub_fix(z[i], hx[i]);
        mat_mul(kx, kg, y, NSTATE, 3, 1);
        for (int i = 0; i < NSTATE; i++) x_corr[i] = add_fix(x_pred[i], kx[i]);
        mat_mul(kh, kg, h, NSTATE, 3, NSTATE);
        for (int i = 0; i < 36; i++)
            kh[i] = sub_fix((i % (NSTATE + 1) == 0) ? ONE_FIX : 0, kh[i]);
        mat_mul(pn, kh, p_pred, NSTATE, NSTATE, NSTATE);
        p_corr = pn;
    endfunction

    function automatic t_estimate filter_step(t_sample s);
        int        v[36];
        t_estimate e;
        for (int i = 0; i < 36; i++) v[i] = 0;
        v[0] = s.va; v[1] = s.vb; v[2] = s.vc;
        e.corr = s.mode;
        if (s.mode) begin
            measurement_update(v);
            for (int i = 0; i < NSTATE; i++) e.v[i] = x_corr[i];
        end else begin
            time_update(v);
            for (int i = 0; i < NSTATE; i++) e.v[i] = x_pred[i];
        end
        return e;
    endfunction

    initial begin
        dt_reg = 655; q_reg = 655; r_xy_reg = 6554; r_z_reg = 65536;
        for (int i = 0; i < 36; i++) begin
            x_corr[i] = 0;
            x_pred[i] = 0;
            p_corr[i] = (i % (NSTATE + 1) == 0 && i < 36) ? ONE_FIX : 0;
            p_pred[i] = p_corr[i];
        end
    end

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Sample accepted items and check results
    always @(posedge i_clk) begin
        t_estimate got;
        t_estimate want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready)
                estimate_q.push_back(filter_step({i_mode, i_value_a, i_value_b, i_value_c}));
            if (o_out_valid && i_out_ready) begin
                got.corr = o_was_correct;
                got.v = {o_bias_c, o_angle_c, o_bias_b, o_angle_b, o_bias_a, o_angle_a};
                n_results++;
                if (estimate_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item at %0t", $realtime);
                end else begin
                    want = estimate_q.pop_front();
                    if (got.corr !== want.corr) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("was_correct: expected %0d got %0d", want.corr, got.corr);
                    end
                    for (int i = 0; i < NSTATE; i++)
                        if (got.v[i] !== want.v[i]) begin
                            mismatches++;
                            if (mismatches <= 10)
                                $display("state %0d (mode %0d): expected %h got %h",
                                         i, want.corr, want.v[i], got.v[i]);
                        end
                end
            end
        end
    end

    // Drive input items from the pending queue, with bursts of idling
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (sample_q.size() > 0) begin
                t_sample s;
                s = sample_q.pop_front();
                i_mode    <= s.mode;
                i_value_a <= s.va;
                i_value_b <= s.vb;
                i_value_c <= s.vc;
                i_in_valid <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 15);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result acceptance: random stalls, plus one long hold to back up the input
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (!long_hold_done && n_results == 40) begin
            long_hold_done <= 1'b1;
            out_gap <= 3000;
            i_out_ready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap <= out_gap - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 7) == 0) out_gap <= $urandom_range(1, 15);
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_TIME_STEP:  dt_reg   = 32'(data) & 32'h1FFFF;
            CFG_PROC_NOISE: q_reg    = 32'(data);
            CFG_MEAS_XY:    r_xy_reg = 32'(data);
            CFG_MEAS_Z:     r_z_reg  = 32'(data);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain_all();
        while (sample_q.size() > 0 || i_in_valid || estimate_q.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7) return $urandom_range(0, 32'h7FFFF) - 32'h3FFFF;
        if (sel < 9) return $urandom_range(0, 32'h3FFFFFF) - 32'h1FFFFFF;
        return $urandom;
    endfunction

    task automatic add_sample(logic mode, logic [31:0] a, logic [31:0] b, logic [31:0] c);
        sample_q.push_back({mode, a, b, c});
    endtask

    // Random phase: mostly predict/correct pairs, some repeated modes
    task automatic random_phase(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 4) == 0)
                add_sample(1'($urandom_range(0, 1)), rand_value(), rand_value(), rand_value());
            else
                add_sample(i[0], rand_value(), rand_value(), rand_value());
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_ready = 1'b0;
        i_mode = 1'b0;
        i_value_a = '0; i_value_b = '0; i_value_c = '0;
        i_cfg_we = 1'b0; i_cfg_idx = CFG_TIME_STEP; i_cfg_data = '0;
        mismatches = 0; n_results = 0; in_gap = 0; out_gap = 0;
        quiet = 1'b0; long_hold_done = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset settings, field extremes, both modes
        add_sample(1'b0, 32'h0, 32'h0, 32'h0);
        add_sample(1'b1, 32'h0, 32'h0, 32'h0);
        add_sample(1'b0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
        add_sample(1'b1, 32'h7FFFFFFF, 32'h80000000, 32'h00000001);
        add_sample(1'b0, 32'h80000000, 32'h7FFFFFFF, 32'h55555555);
        add_sample(1'b1, 32'hAAAAAAAA, 32'h55555555, 32'h80000000);
        add_sample(1'b1, 32'h00010000, 32'hFFFF0000, 32'h7FFFFFFF);
        add_sample(1'b0, 32'h00008000, 32'hFFFF8000, 32'h00000000);
        drain_all();

        // Extreme settings: largest dt, process and Z noise, zero XY measurement noise
        write_reg(CFG_TIME_STEP, 31'h1FFFF);
        write_reg(CFG_PROC_NOISE, 31'h7FFFFFFF);
        write_reg(CFG_MEAS_XY, 31'h0);
        write_reg(CFG_MEAS_Z, 31'h7FFFFFFF);
        add_sample(1'b0, 32'h7FFFFFFF, 32'h80000000, 32'h00010000);
        add_sample(1'b1, 32'h00010000, 32'hFFFF0000, 32'h7FFFFFFF);
        add_sample(1'b0, 32'h00000000, 32'h00000000, 32'h00000000);
        add_sample(1'b1, 32'h80000000, 32'h7FFFFFFF, 32'h00000000);
        drain_all();

        // Zero dt and noise: S diagonal can reach zero or tiny values
        write_reg(CFG_TIME_STEP, 31'h0);
        write_reg(CFG_PROC_NOISE, 31'h0);
        write_reg(CFG_MEAS_XY, 31'h1);
        write_reg(CFG_MEAS_Z, 31'h0);
        add_sample(1'b0, 32'h12345678, 32'h87654321, 32'h0);
        add_sample(1'b1, 32'h00020000, 32'hFFFE0000, 32'h0);
        add_sample(1'b1, 32'h00000000, 32'h00000000, 32'h0);
        add_sample(1'b0, 32'h00000000, 32'h00000000, 32'h0);
        add_sample(1'b1, 32'h00000001, 32'hFFFFFFFF, 32'h1);
        drain_all();

        // dt exactly one second
        write_reg(CFG_TIME_STEP, 31'h10000);
        write_reg(CFG_PROC_NOISE, 31'd655);
        write_reg(CFG_MEAS_XY, 31'd6554);
        write_reg(CFG_MEAS_Z, 31'd65536);
        random_phase(150);
        drain_all();

        // Typical settings back at reset values
        write_reg(CFG_TIME_STEP, 31'd655);
        random_phase(150);
        drain_all();

        // Random settings per phase
        for (int ph = 0; ph < 3; ph++) begin
            write_reg(CFG_TIME_STEP, 31'($urandom_range(0, 17'h1FFFF)));
            write_reg(CFG_PROC_NOISE,
                      31'($urandom_range(0, 31'h7FFFFFFF) >> $urandom_range(0, 30)));
            write_reg(CFG_MEAS_XY,
                      31'($urandom_range(0, 31'h7FFFFFFF) >> $urandom_range(0, 30)));
            write_reg(CFG_MEAS_Z,
                      31'($urandom_range(0, 31'h7FFFFFFF) >> $urandom_range(0, 30)));
            random_phase(130);
            if (ph == 2) begin
                while (sample_q.size() > 40) @(posedge i_clk);
                quiet = 1'b1;
            end
            drain_all();
        end

        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && estimate_q.size() == 0)
            $display("tb_kalman_attitude_filter_3axis: PASS");
        else
            $display("tb_kalman_attitude_filter_3axis: FAIL");
        $finish;
    end

    // Guard against a hung block
    initial begin
        #30_000_000;
        $display("tb_kalman_attitude_filter_3axis: FAIL");
        $finish;
    end

endmodule
